[hdl/deq_pkg.sv]
// ----------------------------------------------------------------------------
// deq_pkg
// Operation and status codes and shared types of the double-ended queue.
// ----------------------------------------------------------------------------
`default_nettype none

package deq_pkg;

  localparam int KIND_W   = 3;
  localparam int STATUS_W = 2;
  localparam int DATA_W   = 32;

  localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DUMP       = 3'd4;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic we;
    logic re;
  } mem_cmd_t;

endpackage

`default_nettype wire

[hdl/deq_if.sv]
// ----------------------------------------------------------------------------
// deq_req_if / deq_rsp_if
// Valid/ready channels carrying operation beats in and result beats out.
// ----------------------------------------------------------------------------
`default_nettype none

interface deq_req_if;
  logic                              valid;
  logic                              ready;
  logic [deq_pkg::KIND_W-1:0]        kind;
  logic signed [deq_pkg::DATA_W-1:0] value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface

interface deq_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [deq_pkg::STATUS_W-1:0]      status;
  logic signed [deq_pkg::DATA_W-1:0] value_res;
  logic                              last;

  modport source (output valid, output status, output value_res, output last, input ready);
  modport sink   (input valid, input status, input value_res, input last, output ready);
endinterface

`default_nettype wire

[hdl/deq_ram.sv]
// ----------------------------------------------------------------------------
// deq_ram
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_ram #(
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic                         clk,
  input  wire deq_pkg::mem_cmd_t            cmd,
  input  wire logic [AW-1:0]                waddr,
  input  wire logic [deq_pkg::DATA_W-1:0]   wdata,
  input  wire logic [AW-1:0]                raddr,
  output logic      [deq_pkg::DATA_W-1:0]   rdata
);

  logic [deq_pkg::DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (cmd.we) begin
      mem[waddr] <= wdata;
    end
    if (cmd.re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[hdl/deq_ctrl.sv]
// ----------------------------------------------------------------------------
// deq_ctrl
// Ring pointers, operation sequencer and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_ctrl #(
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  deq_req_if.sink                         req,
  deq_rsp_if.source                       rsp,
  output deq_pkg::mem_cmd_t               cmd,
  output logic [AW-1:0]                   waddr,
  output logic [deq_pkg::DATA_W-1:0]      wdata,
  output logic [AW-1:0]                   raddr,
  input  wire logic [deq_pkg::DATA_W-1:0] rdata
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_POP  = 3'b010,
    S_DUMP = 3'b100
  } state_t;

  state_t  state, state_next;
  logic [AW-1:0] front, front_next;
  logic [CW-1:0] occ, occ_next;
  logic [CW-1:0] cnt, cnt_next;
  logic [AW-1:0] pos, pos_next;

  logic                          out_valid, out_valid_next;
  logic [deq_pkg::STATUS_W-1:0]  out_status, out_status_next;
  logic [deq_pkg::DATA_W-1:0]    out_value, out_value_next;
  logic                          out_last, out_last_next;

  logic          slot_free, acc, full, empty, ld, dump_last;
  logic [AW:0]   sum_back, sum_last;
  logic [AW-1:0] front_dec, front_inc, pos_inc, back_pos, last_pos;

  assign slot_free = !out_valid || rsp.ready;
  assign req.ready = (state == S_IDLE) && slot_free;
  assign acc       = req.valid && req.ready;
  assign full      = (occ == CW'(DEPTH));
  assign empty     = (occ == '0);

  assign front_dec = (front == '0) ? AW'(DEPTH - 1) : front - AW'(1);
  assign front_inc = (front == AW'(DEPTH - 1)) ? '0 : front + AW'(1);
  assign pos_inc   = (pos == AW'(DEPTH - 1)) ? '0 : pos + AW'(1);
  assign sum_back  = {1'b0, front} + (AW+1)'(occ);
  assign sum_last  = sum_back - (AW+1)'(1);
  assign back_pos  = (sum_back >= (AW+1)'(DEPTH)) ? AW'(sum_back - (AW+1)'(DEPTH))
                                                  : AW'(sum_back);
  assign last_pos  = (sum_last >= (AW+1)'(DEPTH)) ? AW'(sum_last - (AW+1)'(DEPTH))
                                                  : AW'(sum_last);
  assign dump_last = ((cnt + CW'(1)) == occ);

  assign wdata = req.value;

  always_comb begin
    state_next      = state;
    front_next      = front;
    occ_next        = occ;
    cnt_next        = cnt;
    pos_next        = pos;
    cmd.we          = 1'b0;
    cmd.re          = 1'b0;
    waddr           = front_dec;
    raddr           = front;
    ld              = 1'b0;
    out_status_next = out_status;
    out_value_next  = out_value;
    out_last_next   = out_last;

    case (state)
      S_IDLE: begin
        if (acc) begin
          case (req.kind)
            deq_pkg::KIND_PUSH_FRONT, deq_pkg::KIND_PUSH_BACK: begin
              ld              = 1'b1;
              out_value_next  = '0;
              out_last_next   = 1'b1;
              if (full) begin
                out_status_next = deq_pkg::STATUS_FULL;
              end else begin
                out_status_next = deq_pkg::STATUS_OK;
                cmd.we          = 1'b1;
                occ_next        = occ + CW'(1);
                if (req.kind == deq_pkg::KIND_PUSH_FRONT) begin
                  waddr      = front_dec;
                  front_next = front_dec;
                end else begin
                  waddr = back_pos;
                end
              end
            end
            deq_pkg::KIND_POP_FRONT, deq_pkg::KIND_POP_BACK: begin
              if (empty) begin
                ld              = 1'b1;
                out_status_next = deq_pkg::STATUS_EMPTY;
                out_value_next  = '0;
                out_last_next   = 1'b1;
              end else begin
                cmd.re     = 1'b1;
                occ_next   = occ - CW'(1);
                state_next = S_POP;
                if (req.kind == deq_pkg::KIND_POP_FRONT) begin
                  raddr      = front;
                  front_next = front_inc;
                end else begin
                  raddr = last_pos;
                end
              end
            end
            deq_pkg::KIND_DUMP: begin
              if (empty) begin
                ld              = 1'b1;
                out_status_next = deq_pkg::STATUS_EMPTY;
                out_value_next  = '0;
                out_last_next   = 1'b1;
              end else begin
                cmd.re     = 1'b1;
                raddr      = front;
                pos_next   = front_inc;
                cnt_next   = '0;
                state_next = S_DUMP;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_POP: begin
        if (slot_free) begin
          ld              = 1'b1;
          out_status_next = deq_pkg::STATUS_OK;
          out_value_next  = rdata;
          out_last_next   = 1'b1;
          state_next      = S_IDLE;
        end
      end
      S_DUMP: begin
        if (slot_free) begin
          ld              = 1'b1;
          out_status_next = deq_pkg::STATUS_OK;
          out_value_next  = rdata;
          out_last_next   = dump_last;
          if (dump_last) begin
            state_next = S_IDLE;
          end else begin
            cmd.re   = 1'b1;
            raddr    = pos;
            pos_next = pos_inc;
            cnt_next = cnt + CW'(1);
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (ld) begin
      out_valid_next = 1'b1;
    end else if (rsp.ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      front     <= '0;
      occ       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      front     <= front_next;
      occ       <= occ_next;
      out_valid <= out_valid_next;
    end
    cnt        <= cnt_next;
    pos        <= pos_next;
    out_status <= out_status_next;
    out_value  <= out_value_next;
    out_last   <= out_last_next;
  end

  assign rsp.valid     = out_valid;
  assign rsp.status    = out_status;
  assign rsp.value_res = out_value;
  assign rsp.last      = out_last;

endmodule

`default_nettype wire

[hdl/double_ended_queue_core.sv]
// ----------------------------------------------------------------------------
// double_ended_queue_core
// Bounded double-ended queue of signed 32-bit values in a ring store.
//
//   channel  dir  beat fields
//   req      in   kind, value
//   rsp      out  status, value_res, last
//
// Push: result registered at accept (write into the entry store).
// Pop: result loaded from the registered read data of the entry store.
// Dump of n entries: one store read per result beat; req is held off until
// the final beat is loaded. Result register frees req while a beat waits,
// if rsp takes it in the same cycle. Reset clears the front pointer and the
// occupancy count; entry contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_queue_core #(
  parameter int DEPTH = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  deq_req_if.sink   req,
  deq_rsp_if.source rsp
);

  localparam int AW = $clog2(DEPTH);

  deq_pkg::mem_cmd_t          cmd;
  logic [AW-1:0]              waddr, raddr;
  logic [deq_pkg::DATA_W-1:0] wdata, rdata;

  deq_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .req   (req),
    .rsp   (rsp),
    .cmd   (cmd),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  deq_ram #(.DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .cmd   (cmd),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

endmodule

`default_nettype wire
